// ===== rtl/multi_mode_rate_limiter_assert.svh =====
// assertion macros for the rate limiter back end
`ifndef MULTI_MODE_RATE_LIMITER_ASSERT_SVH
`define MULTI_MODE_RATE_LIMITER_ASSERT_SVH

// condition must hold at every edge out of reset
`define MMRL_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when pre holds, post must hold at the same edge
`define MMRL_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/mmrl_pkg.sv =====
`timescale 1ns / 1ps
package mmrl_pkg;

  localparam int LOG_DEPTH    = 1024;
  localparam int CLIENT_SLOTS = 16;

  localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LCW    = $clog2(LOG_DEPTH + 1);
  localparam int CIW    = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int CCW    = $clog2(CLIENT_SLOTS + 1);
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int LVL_W  = 26;
  localparam int PROD_W = 48;
  localparam int CFG_IW = 4;

  localparam logic [LVL_W-1:0] MILLI   = 26'd1000;
  localparam logic [15:0]      DEF_CAP = 16'd10;
  localparam logic [15:0]      DEF_WIN = 16'd1000;
  localparam logic [15:0]      RST_RATE = 16'd10;
  localparam logic [15:0]      RST_BURST = 16'd0;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_MODE  = 4'd0;
  localparam logic [CFG_IW-1:0] REG_RATE  = 4'd1;
  localparam logic [CFG_IW-1:0] REG_BURST = 4'd2;
  localparam logic [CFG_IW-1:0] REG_WIN   = 4'd3;

  typedef enum logic [1:0] {
    MODE_TOKEN,
    MODE_LEAKY,
    MODE_WINDOW,
    MODE_SLIDE
  } mode_t;

  typedef enum logic [1:0] {
    RSN_OK,
    RSN_GLOBAL,
    RSN_CLIENT,
    RSN_FULL
  } reason_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_FULL,
    ST_NEW,
    ST_GLOB,
    ST_GUPD,
    ST_EVRD,
    ST_EVCMP,
    ST_CRD,
    ST_CWR,
    ST_DEC
  } state_t;

  typedef struct packed {
    logic              wr;
    logic [CFG_IW-1:0] index;
    logic [15:0]       data;
  } cfg_wr_t;

  typedef struct packed {
    logic           cmd;
    logic           full;
    logic           is_new;
    logic [CIW-1:0] idx;
    logic [31:0]    now;
  } q_entry_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [31:0]      last;
    logic [31:0]      wstart;
    logic [15:0]      wcnt;
  } client_rec_t;

  // bucket capacity in thousandths
  function automatic logic [LVL_W-1:0] cap_of(logic [15:0] rate, logic [15:0] burst);
    logic [15:0] c;
    c = (burst != 16'd0) ? burst : ((rate != 16'd0) ? rate : DEF_CAP);
    return LVL_W'(c) * MILLI;
  endfunction

  // token refill clamped at capacity
  function automatic logic [LVL_W-1:0] fill_up(logic [LVL_W-1:0] level,
                                               logic [PROD_W-1:0] prod,
                                               logic [LVL_W-1:0] cap);
    logic [PROD_W:0] s;
    s = (PROD_W+1)'(level) + (PROD_W+1)'(prod);
    return (s > (PROD_W+1)'(cap)) ? cap : s[LVL_W-1:0];
  endfunction

  // leaky drain clamped at zero
  function automatic logic [LVL_W-1:0] drain(logic [LVL_W-1:0] level,
                                             logic [PROD_W-1:0] prod);
    return (prod >= PROD_W'(level)) ? '0 : level - prod[LVL_W-1:0];
  endfunction

endpackage

// ===== rtl/mmrl_front.sv =====
`timescale 1ns / 1ps
module mmrl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  mmrl_pkg::cfg_wr_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [31:0]         in_client_key,
  input  logic [31:0]         in_now_ms,
  output logic                q_push,
  output mmrl_pkg::q_entry_t  q_data,
  input  logic                q_full
);

  logic [31:0]             key_r [mmrl_pkg::CLIENT_SLOTS];
  logic [mmrl_pkg::CCW-1:0] used_r, used_nxt;
  logic                    hit, full, acc;
  logic [mmrl_pkg::CIW-1:0] hit_idx;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // key lookup over the used slots
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < mmrl_pkg::CLIENT_SLOTS; i++) begin
      if (!hit && (mmrl_pkg::CCW'(i) < used_r) && (key_r[i] == in_client_key)) begin
        hit     = 1'b1;
        hit_idx = mmrl_pkg::CIW'(i);
      end
    end
  end

  assign full = !hit && (used_r >= mmrl_pkg::CCW'(mmrl_pkg::CLIENT_SLOTS));

  // classified word for the back end
  always_comb begin
    q_data.cmd    = in_cmd;
    q_data.full   = in_cmd && full;
    q_data.is_new = in_cmd && !hit && !full;
    q_data.idx    = hit ? hit_idx : used_r[mmrl_pkg::CIW-1:0];
    q_data.now    = in_now_ms;
  end

  assign q_push = acc;

  always_comb begin
    used_nxt = used_r;
    if (cfg.wr) begin
      used_nxt = '0;
    end else if (acc && q_data.is_new) begin
      used_nxt = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // key table, written on insert
  always_ff @(posedge clk) begin
    if (acc && q_data.is_new) begin
      key_r[used_r[mmrl_pkg::CIW-1:0]] <= in_client_key;
    end
  end

endmodule

// ===== rtl/mmrl_fifo.sv =====
`timescale 1ns / 1ps
module mmrl_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mmrl_pkg::q_entry_t din,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output mmrl_pkg::q_entry_t dout
);

  mmrl_pkg::q_entry_t       mem_r [mmrl_pkg::QDEPTH];
  logic [mmrl_pkg::QPW-1:0] wp_r, rp_r;
  logic [mmrl_pkg::QCW-1:0] cnt_r;

  assign full  = (cnt_r == mmrl_pkg::QCW'(mmrl_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == mmrl_pkg::QPW'(mmrl_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == mmrl_pkg::QPW'(mmrl_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== rtl/mmrl_back.sv =====
`timescale 1ns / 1ps
`include "multi_mode_rate_limiter_assert.svh"
module mmrl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mmrl_pkg::cfg_wr_t  cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  mmrl_pkg::q_entry_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_granted,
  output logic [1:0]         out_reason
);

  mmrl_pkg::state_t st_r, st_nxt;

  // configuration
  mmrl_pkg::mode_t  mode_r;
  logic [15:0]      rate_r, burst_r, win_ms_r;
  logic [mmrl_pkg::LVL_W-1:0] cap_r, cap_nxt;
  logic             init_pend_r;

  // global limiter state
  logic [mmrl_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [31:0]      last_r, last_nxt, wstart_r, wstart_nxt;
  logic [15:0]      wcnt_r, wcnt_nxt;

  // sliding log
  logic [31:0]                 log_mem [mmrl_pkg::LOG_DEPTH];
  logic [31:0]                 mem_q_r;
  logic [mmrl_pkg::LOG_AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [mmrl_pkg::LCW-1:0]    lcnt_r, lcnt_nxt;
  logic                        log_we;

  // client records
  mmrl_pkg::client_rec_t    crec_r [mmrl_pkg::CLIENT_SLOTS];
  mmrl_pkg::client_rec_t    crec_rd, crec_wd, rec_r, rec_nxt, sel_r, sel_nxt, nrec;
  logic                     crec_we;
  logic [mmrl_pkg::CIW-1:0] crec_wa;
  logic [mmrl_pkg::CCW-1:0] used_r, used_nxt, ci_r, ci_nxt;

  // current item and shared multiplier
  mmrl_pkg::q_entry_t job_r, job_nxt;
  logic [mmrl_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [31:0]        mul_a;

  logic               out_valid_r, out_valid_nxt, out_granted_r, out_granted_nxt;
  mmrl_pkg::reason_t  out_reason_r, out_reason_nxt;

  logic [15:0] win_len;
  logic [31:0] slide_ws, lim;
  logic        cl_walk, client_chk, cl_refuse, g_ok;

  // assertion helpers
  logic        bkt_chk, dec_st;

  assign win_len  = (win_ms_r != 16'd0) ? win_ms_r : mmrl_pkg::DEF_WIN;
  assign slide_ws = (job_r.now >= 32'(win_len)) ? job_r.now - 32'(win_len) : '0;
  assign lim      = (32'(rate_r) < 32'(mmrl_pkg::LOG_DEPTH)) ? 32'(rate_r)
                                                             : 32'(mmrl_pkg::LOG_DEPTH);
  assign cl_walk  = (mode_r == mmrl_pkg::MODE_TOKEN) || (mode_r == mmrl_pkg::MODE_WINDOW);
  assign crec_rd  = crec_r[ci_r[mmrl_pkg::CIW-1:0]];
  assign mul_a    = (st_r == mmrl_pkg::ST_GLOB) ? job_r.now - last_r
                                                : job_r.now - crec_rd.last;

  assign client_chk = job_r.cmd && cl_walk;
  assign cl_refuse  = (mode_r == mmrl_pkg::MODE_TOKEN) ? (sel_r.level < mmrl_pkg::MILLI)
                                                       : (sel_r.wcnt >= rate_r);

  // global admission test
  always_comb begin
    case (mode_r)
      mmrl_pkg::MODE_TOKEN:  g_ok = (lvl_r >= mmrl_pkg::MILLI);
      mmrl_pkg::MODE_LEAKY:  g_ok = ((mmrl_pkg::LVL_W+1)'(lvl_r) +
                                     (mmrl_pkg::LVL_W+1)'(mmrl_pkg::MILLI))
                                    <= (mmrl_pkg::LVL_W+1)'(cap_r);
      mmrl_pkg::MODE_WINDOW: g_ok = (wcnt_r < rate_r);
      default:               g_ok = (32'(lcnt_r) < lim);
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mmrl_pkg::ST_IDLE: begin
        if (init_pend_r) begin
          st_nxt = mmrl_pkg::ST_INIT;
        end else if (q_valid && !out_valid_r) begin
          if (q_data.full) begin
            st_nxt = mmrl_pkg::ST_FULL;
          end else if (q_data.is_new) begin
            st_nxt = mmrl_pkg::ST_NEW;
          end else begin
            st_nxt = mmrl_pkg::ST_GLOB;
          end
        end
      end
      mmrl_pkg::ST_INIT: st_nxt = mmrl_pkg::ST_IDLE;
      mmrl_pkg::ST_FULL: st_nxt = mmrl_pkg::ST_IDLE;
      mmrl_pkg::ST_NEW:  st_nxt = mmrl_pkg::ST_GLOB;
      mmrl_pkg::ST_GLOB: begin
        if (mode_r == mmrl_pkg::MODE_SLIDE) begin
          st_nxt = mmrl_pkg::ST_EVRD;
        end else if (mode_r == mmrl_pkg::MODE_WINDOW) begin
          st_nxt = mmrl_pkg::ST_CRD;
        end else begin
          st_nxt = mmrl_pkg::ST_GUPD;
        end
      end
      mmrl_pkg::ST_GUPD:  st_nxt = mmrl_pkg::ST_CRD;
      mmrl_pkg::ST_EVRD:  st_nxt = (lcnt_r == '0) ? mmrl_pkg::ST_DEC : mmrl_pkg::ST_EVCMP;
      mmrl_pkg::ST_EVCMP: st_nxt = (mem_q_r < slide_ws) ? mmrl_pkg::ST_EVRD : mmrl_pkg::ST_DEC;
      mmrl_pkg::ST_CRD: begin
        st_nxt = (!cl_walk || ci_r >= used_r) ? mmrl_pkg::ST_DEC : mmrl_pkg::ST_CWR;
      end
      mmrl_pkg::ST_CWR: st_nxt = mmrl_pkg::ST_CRD;
      mmrl_pkg::ST_DEC: st_nxt = mmrl_pkg::ST_IDLE;
      default:          st_nxt = mmrl_pkg::ST_IDLE;
    endcase
  end

  // datapath per state
  always_comb begin
    q_pop           = 1'b0;
    job_nxt         = job_r;
    cap_nxt         = cap_r;
    lvl_nxt         = lvl_r;
    last_nxt        = last_r;
    wstart_nxt      = wstart_r;
    wcnt_nxt        = wcnt_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    lcnt_nxt        = lcnt_r;
    log_we          = 1'b0;
    used_nxt        = used_r;
    ci_nxt          = ci_r;
    rec_nxt         = rec_r;
    sel_nxt         = sel_r;
    prod_nxt        = prod_r;
    crec_we         = 1'b0;
    crec_wa         = job_r.idx;
    crec_wd         = sel_r;
    nrec            = rec_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_reason_nxt  = out_reason_r;

    unique case (st_r)
      mmrl_pkg::ST_IDLE: begin
        if (!init_pend_r && q_valid && !out_valid_r) begin
          q_pop   = 1'b1;
          job_nxt = q_data;
        end
      end
      mmrl_pkg::ST_INIT: begin
        cap_nxt    = mmrl_pkg::cap_of(rate_r, burst_r);
        lvl_nxt    = (mode_r == mmrl_pkg::MODE_TOKEN) ? cap_nxt : '0;
        last_nxt   = '0;
        wstart_nxt = '0;
        wcnt_nxt   = '0;
        head_nxt   = '0;
        tail_nxt   = '0;
        lcnt_nxt   = '0;
        used_nxt   = '0;
      end
      mmrl_pkg::ST_FULL: begin
        out_valid_nxt   = 1'b1;
        out_granted_nxt = 1'b0;
        out_reason_nxt  = mmrl_pkg::RSN_FULL;
      end
      mmrl_pkg::ST_NEW: begin
        crec_we        = 1'b1;
        crec_wa        = used_r[mmrl_pkg::CIW-1:0];
        crec_wd.level  = (mode_r == mmrl_pkg::MODE_TOKEN) ? cap_r : '0;
        crec_wd.last   = job_r.now;
        crec_wd.wstart = job_r.now;
        crec_wd.wcnt   = '0;
        used_nxt       = used_r + 1'b1;
      end
      mmrl_pkg::ST_GLOB: begin
        ci_nxt   = '0;
        prod_nxt = mmrl_pkg::PROD_W'(mul_a) * mmrl_pkg::PROD_W'(rate_r);
        if ((mode_r == mmrl_pkg::MODE_WINDOW) &&
            (job_r.now - wstart_r >= 32'(win_len))) begin
          wstart_nxt = job_r.now;
          wcnt_nxt   = '0;
        end
      end
      mmrl_pkg::ST_GUPD: begin
        lvl_nxt  = (mode_r == mmrl_pkg::MODE_TOKEN) ? mmrl_pkg::fill_up(lvl_r, prod_r, cap_r)
                                                    : mmrl_pkg::drain(lvl_r, prod_r);
        last_nxt = job_r.now;
      end
      mmrl_pkg::ST_EVRD: begin
      end
      mmrl_pkg::ST_EVCMP: begin
        // drop the oldest entry when it falls before the window
        if (mem_q_r < slide_ws) begin
          head_nxt = (head_r == mmrl_pkg::LOG_AW'(mmrl_pkg::LOG_DEPTH - 1)) ? '0
                                                                            : head_r + 1'b1;
          lcnt_nxt = lcnt_r - 1'b1;
        end
      end
      mmrl_pkg::ST_CRD: begin
        rec_nxt  = crec_rd;
        prod_nxt = mmrl_pkg::PROD_W'(mul_a) * mmrl_pkg::PROD_W'(rate_r);
      end
      mmrl_pkg::ST_CWR: begin
        if (mode_r == mmrl_pkg::MODE_TOKEN) begin
          nrec.level = mmrl_pkg::fill_up(rec_r.level, prod_r, cap_r);
          nrec.last  = job_r.now;
        end else if (job_r.now - rec_r.wstart >= 32'(win_len)) begin
          nrec.wstart = job_r.now;
          nrec.wcnt   = '0;
        end
        crec_we = 1'b1;
        crec_wa = ci_r[mmrl_pkg::CIW-1:0];
        crec_wd = nrec;
        if (job_r.cmd && (ci_r[mmrl_pkg::CIW-1:0] == job_r.idx)) begin
          sel_nxt = nrec;
        end
        ci_nxt = ci_r + 1'b1;
      end
      mmrl_pkg::ST_DEC: begin
        out_valid_nxt = 1'b1;
        if (client_chk && cl_refuse) begin
          out_granted_nxt = 1'b0;
          out_reason_nxt  = mmrl_pkg::RSN_CLIENT;
        end else if (g_ok) begin
          out_granted_nxt = 1'b1;
          out_reason_nxt  = mmrl_pkg::RSN_OK;
          case (mode_r)
            mmrl_pkg::MODE_TOKEN:  lvl_nxt = lvl_r - mmrl_pkg::MILLI;
            mmrl_pkg::MODE_LEAKY:  lvl_nxt = lvl_r + mmrl_pkg::MILLI;
            mmrl_pkg::MODE_WINDOW: wcnt_nxt = wcnt_r + 1'b1;
            default: begin
              log_we   = 1'b1;
              tail_nxt = (tail_r == mmrl_pkg::LOG_AW'(mmrl_pkg::LOG_DEPTH - 1)) ? '0
                                                                                : tail_r + 1'b1;
              lcnt_nxt = lcnt_r + 1'b1;
            end
          endcase
          // charge the client's own bucket or window
          if (client_chk) begin
            crec_we = 1'b1;
            crec_wa = job_r.idx;
            crec_wd = sel_r;
            if (mode_r == mmrl_pkg::MODE_TOKEN) begin
              crec_wd.level = sel_r.level - mmrl_pkg::MILLI;
            end else begin
              crec_wd.wcnt = sel_r.wcnt + 1'b1;
            end
          end
        end else begin
          out_granted_nxt = 1'b0;
          out_reason_nxt  = mmrl_pkg::RSN_GLOBAL;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mmrl_pkg::ST_IDLE;
      mode_r      <= mmrl_pkg::MODE_TOKEN;
      rate_r      <= mmrl_pkg::RST_RATE;
      burst_r     <= mmrl_pkg::RST_BURST;
      win_ms_r    <= mmrl_pkg::DEF_WIN;
      init_pend_r <= 1'b1;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      ci_r        <= '0;
      lcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      ci_r        <= ci_nxt;
      lcnt_r      <= lcnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (cfg.wr) begin
        init_pend_r <= 1'b1;
        case (cfg.index)
          mmrl_pkg::REG_MODE:  mode_r   <= mmrl_pkg::mode_t'(cfg.data[1:0]);
          mmrl_pkg::REG_RATE:  rate_r   <= cfg.data;
          mmrl_pkg::REG_BURST: burst_r  <= cfg.data;
          default:             win_ms_r <= cfg.data;
        endcase
      end else if (st_r == mmrl_pkg::ST_INIT) begin
        init_pend_r <= 1'b0;
      end
    end
  end

  // state set up by the init step, and per-item payload
  always_ff @(posedge clk) begin
    cap_r         <= cap_nxt;
    lvl_r         <= lvl_nxt;
    last_r        <= last_nxt;
    wstart_r      <= wstart_nxt;
    wcnt_r        <= wcnt_nxt;
    job_r         <= job_nxt;
    prod_r        <= prod_nxt;
    rec_r         <= rec_nxt;
    sel_r         <= sel_nxt;
    out_granted_r <= out_granted_nxt;
    out_reason_r  <= out_reason_nxt;
  end

  // client record store
  always_ff @(posedge clk) begin
    if (crec_we) begin
      crec_r[crec_wa] <= crec_wd;
    end
  end

  // log ring memory, registered read at the head
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[tail_r] <= job_r.now;
    end
    mem_q_r <= log_mem[head_r];
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_reason  = out_reason_r;

  assign bkt_chk = !init_pend_r && (st_r != mmrl_pkg::ST_INIT) &&
                   ((mode_r == mmrl_pkg::MODE_TOKEN) || (mode_r == mmrl_pkg::MODE_LEAKY));
  assign dec_st  = (st_r == mmrl_pkg::ST_DEC) || (st_r == mmrl_pkg::ST_FULL);

  `MMRL_CHECK(a_lcnt_bound, lcnt_r <= mmrl_pkg::LCW'(mmrl_pkg::LOG_DEPTH), "log count past depth")
  `MMRL_CHECK(a_used_bound, used_r <= mmrl_pkg::CCW'(mmrl_pkg::CLIENT_SLOTS), "client overflow")
  `MMRL_IMPLY(a_lvl_cap, bkt_chk, lvl_r <= cap_r, "bucket level above capacity")
  `MMRL_IMPLY(a_out_src, $rose(out_valid_r), $past(dec_st), "result raised outside decision")

endmodule

// ===== rtl/multi_mode_rate_limiter.sv =====
`timescale 1ns / 1ps
// Request rate limiter with token bucket, leaky bucket, fixed window and
// sliding log modes, plus a 16-slot client table.
// in_*  : request word (cmd, client_key, now_ms), valid/ready.
// out_* : decision word (granted, reason), valid/ready, one per request.
// cfg_* : register writes (mode, rate, burst, window length by index); a write
//         re-initializes all limiter state and empties the client table.
// A front stage looks up or inserts the client key and pushes the request
// into a 2-deep queue; a back sequencer updates the global limiter, walks
// every client record in token and fixed-window modes (one shared 32x16
// multiplier) and then decides.
// From queue pop, token mode runs the global update, the client walk and
// the decision; fixed-window mode skips the bucket update, leaky mode the
// walk, and sliding-log mode evicts stale log entries before deciding; a
// full client table goes straight to a refusal; a new client adds an insert
// step. The next request is popped once the decision word has been taken.
// Reset loads rate 10, window 1000 ms, token mode, and runs the init step
// (as after every register write) before a request is popped.
// When out_ready is low the decision stays held; the queue keeps accepting
// until it fills, then in_ready drops.
module multi_mode_rate_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_client_key,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic [1:0]  out_reason,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mmrl_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  mmrl_pkg::cfg_wr_t  cfg_s;
  mmrl_pkg::q_entry_t push_data, pop_data;
  logic               q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  // only known register indexes take effect
  always_comb begin
    cfg_s.wr    = cfg_valid && (cfg_index <= mmrl_pkg::REG_WIN);
    cfg_s.index = cfg_index;
    cfg_s.data  = cfg_data;
  end

  mmrl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_s),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_client_key (in_client_key),
    .in_now_ms     (in_now_ms),
    .q_push        (q_push),
    .q_data        (push_data),
    .q_full        (q_full)
  );

  mmrl_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (pop_data)
  );

  mmrl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_s),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_granted (out_granted),
    .out_reason  (out_reason)
  );

endmodule
